/* sv/sfbw_pkg.sv */
// Shared types and constants for the sector flash byte writer.
// No dependencies; imported by sector_flash_byte_writer, sfbw_checker and tb_top.
package sfbw_pkg;

  localparam int ADDR_W    = 12;   // width of a request start address
  localparam int LEN_W     = 8;    // width of a request length / item index
  localparam int DATA_W    = 8;
  localparam int STG_DEPTH = 256;  // staging buffer entries
  localparam int STG_AW    = 8;
  localparam int ADDR_SPAN = 4096; // highest start address plus one

  localparam int FLASH_BYTES_DEF    = 4096;
  localparam int SECTOR_BYTES_DEF   = 512;
  localparam int RESERVED_BYTES_DEF = 1024;
  localparam int MAX_REQUEST_DEF    = 255;

  localparam logic [DATA_W-1:0] ERASED = 8'hFF;

  localparam logic REQ_READ   = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_PROG,
    ST_ALIGN,
    ST_ERASE_B,
    ST_COPY_TB,
    ST_ERASE_T,
    ST_COPY_BT
  } state_t;

endpackage

/* sv/sector_flash_byte_writer.sv */
// Byte-writable storage over a sector-erase flash array kept in on-chip memory.
// Reads, non-final writes: one item per cycle while idle; read result next cycle, no stall.
// Final in-range write: erase check sweep, then either a program sweep or the erase path:
//   align to start sector, erase backup, copy target to backup, erase target, copy back
//   (2 erases, 2 copies; copies skipped when the target is the backup sector).
// Reset (synchronous, rst_n low) then erases the array, busy high.
module sector_flash_byte_writer #(
  parameter int FLASH_BYTES    = sfbw_pkg::FLASH_BYTES_DEF,
  parameter int SECTOR_BYTES   = sfbw_pkg::SECTOR_BYTES_DEF,
  parameter int RESERVED_BYTES = sfbw_pkg::RESERVED_BYTES_DEF,
  parameter int MAX_REQUEST    = sfbw_pkg::MAX_REQUEST_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [sfbw_pkg::ADDR_W-1:0]   in_start_addr,
  input  logic [sfbw_pkg::LEN_W-1:0]    in_length,
  input  logic [sfbw_pkg::DATA_W-1:0]   in_write_data,
  input  logic                          in_last,
  output logic                          out_valid,
  output logic [sfbw_pkg::DATA_W-1:0]   out_read_data,
  output logic                          out_status,
  output logic                          out_result_kind,
  output logic                          out_did_erase
);
  import sfbw_pkg::*;

  localparam int USER_BYTES = (FLASH_BYTES > RESERVED_BYTES) ?
                              (FLASH_BYTES - RESERVED_BYTES) : 0;
  localparam int BACKUP     = (USER_BYTES / SECTOR_BYTES) * SECTOR_BYTES;
  localparam int FA_W       = $clog2(FLASH_BYTES);
  localparam int AW         = $clog2(FLASH_BYTES + SECTOR_BYTES + ADDR_SPAN + 1);

  localparam logic [AW-1:0] USER_A   = AW'(USER_BYTES);
  localparam logic [AW-1:0] FLASH_A  = AW'(FLASH_BYTES);
  localparam logic [AW-1:0] SECTOR_A = AW'(SECTOR_BYTES);
  localparam logic [AW-1:0] BACKUP_A = AW'(BACKUP);
  localparam logic [LEN_W:0] MAX_A   = (LEN_W+1)'(MAX_REQUEST);

  // memories
  logic [DATA_W-1:0] flash_mem [FLASH_BYTES];
  logic [DATA_W-1:0] stg_mem   [STG_DEPTH];

  state_t            state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  byte_count_r, byte_count_nxt;
  logic              p_v_r, p_v_nxt;
  logic [AW-1:0]     p_dst_r, p_dst_nxt;
  logic              p_src_ok_r, p_src_ok_nxt;
  logic              p_merge_r, p_merge_nxt;
  logic              need_r, need_nxt;
  logic [AW-1:0]     off_r, off_nxt;
  logic [AW-1:0]     tgt_r, tgt_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_rd_ok_r, out_rd_ok_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic              out_erase_r, out_erase_nxt;

  logic [DATA_W-1:0] flash_q_r, stg_q_r;

  logic              fl_we;
  logic [AW-1:0]     fl_waddr, fl_raddr;
  logic [DATA_W-1:0] fl_wdata;
  logic              st_we;
  logic [STG_AW-1:0] st_raddr;

  logic              accept;
  logic [AW-1:0]     in_addr, req_end;
  logic              range_bad, rd_bad, idx_lt_max;
  logic [LEN_W:0]    staged;
  logic [LEN_W-1:0]  len_in;

  logic              sweep, merge;
  logic [AW-1:0]     sweep_end, src_a, dst_a, mrg_idx;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign in_addr    = AW'(in_start_addr) + AW'(byte_count_r);
  assign req_end    = AW'(in_start_addr) + AW'(in_length);
  assign range_bad  = (req_end > USER_A);
  assign rd_bad     = range_bad || (in_addr >= USER_A);
  assign idx_lt_max = ({1'b0, byte_count_r} < MAX_A);
  assign staged     = idx_lt_max ? ({1'b0, byte_count_r} + (LEN_W+1)'(1)) : MAX_A;
  assign len_in     = ({1'b0, in_length} < staged) ? in_length : staged[LEN_W-1:0];

  assign st_we   = accept && (in_req_type == REQ_WRITE) && idx_lt_max;
  assign mrg_idx = cnt_r - off_r;

  always_comb begin
    byte_count_nxt = byte_count_r;
    if (accept) begin
      if (in_last) begin
        byte_count_nxt = '0;
      end else if (idx_lt_max) begin
        byte_count_nxt = byte_count_r + LEN_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    p_v_nxt       = 1'b0;
    p_dst_nxt     = p_dst_r;
    p_src_ok_nxt  = p_src_ok_r;
    p_merge_nxt   = p_merge_r;
    need_nxt      = need_r;
    off_nxt       = off_r;
    tgt_nxt       = tgt_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    out_valid_nxt = 1'b0;
    out_rd_ok_nxt = 1'b0;
    out_status_nxt = STAT_OK;
    out_kind_nxt  = KIND_READ;
    out_erase_nxt = 1'b0;
    fl_we         = 1'b0;
    fl_waddr      = cnt_r;
    fl_wdata      = ERASED;
    fl_raddr      = in_addr;
    st_raddr      = cnt_r[STG_AW-1:0];
    sweep         = 1'b0;
    sweep_end     = AW'(len_r);
    src_a         = AW'(start_r) + cnt_r;
    dst_a         = AW'(start_r) + cnt_r;
    merge         = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        if (cnt_r < FLASH_A) begin
          fl_we   = 1'b1;
          cnt_nxt = cnt_r + AW'(1);
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_READ) begin
            out_valid_nxt  = 1'b1;
            out_rd_ok_nxt  = !rd_bad;
            out_status_nxt = rd_bad ? STAT_RANGE : STAT_OK;
          end else if (in_last) begin
            if (range_bad) begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_WRITE;
              out_status_nxt = STAT_RANGE;
            end else begin
              state_nxt = ST_CHECK;
              cnt_nxt   = '0;
              need_nxt  = 1'b0;
              start_nxt = in_start_addr;
              len_nxt   = len_in;
              off_nxt   = AW'(in_start_addr);
              tgt_nxt   = '0;
            end
          end
        end
      end
      ST_CHECK: begin
        sweep = 1'b1;
        if (p_v_r && (flash_q_r != stg_q_r) && (flash_q_r != ERASED)) begin
          need_nxt = 1'b1;
        end
      end
      ST_PROG: begin
        sweep = 1'b1;
      end
      ST_ALIGN: begin
        // sector base of the start address by repeated subtraction
        if (off_r >= SECTOR_A) begin
          off_nxt = off_r - SECTOR_A;
          tgt_nxt = tgt_r + SECTOR_A;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_ERASE_B;
        end
      end
      ST_ERASE_B: begin
        if (cnt_r < SECTOR_A) begin
          fl_waddr = BACKUP_A + cnt_r;
          fl_we    = (fl_waddr < FLASH_A);
          cnt_nxt  = cnt_r + AW'(1);
        end else begin
          cnt_nxt   = '0;
          state_nxt = (tgt_r == BACKUP_A) ? ST_ERASE_T : ST_COPY_TB;
        end
      end
      ST_COPY_TB: begin
        sweep     = 1'b1;
        sweep_end = SECTOR_A;
        src_a     = tgt_r + cnt_r;
        dst_a     = BACKUP_A + cnt_r;
      end
      ST_ERASE_T: begin
        if (cnt_r < SECTOR_A) begin
          fl_waddr = tgt_r + cnt_r;
          fl_we    = (fl_waddr < FLASH_A);
          cnt_nxt  = cnt_r + AW'(1);
        end else begin
          cnt_nxt = '0;
          if (tgt_r == BACKUP_A) begin
            // target is the backup sector: left erased
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_WRITE;
            out_erase_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_COPY_BT;
          end
        end
      end
      ST_COPY_BT: begin
        sweep     = 1'b1;
        sweep_end = SECTOR_A;
        src_a     = BACKUP_A + cnt_r;
        dst_a     = tgt_r + cnt_r;
        merge     = (cnt_r >= off_r) && (cnt_r < off_r + AW'(len_r));
        st_raddr  = mrg_idx[STG_AW-1:0];
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // read stage issues cnt_r, write stage retires the previous index
    if (sweep) begin
      fl_raddr = src_a;
      if (cnt_r < sweep_end) begin
        p_v_nxt      = 1'b1;
        p_dst_nxt    = dst_a;
        p_src_ok_nxt = (src_a < FLASH_A);
        p_merge_nxt  = merge;
        cnt_nxt      = cnt_r + AW'(1);
      end
      if (p_v_r && (state_r != ST_CHECK)) begin
        fl_waddr = p_dst_r;
        fl_we    = (p_dst_r < FLASH_A);
        if (state_r == ST_PROG) begin
          fl_wdata = flash_q_r & stg_q_r;
        end else if (p_merge_r) begin
          fl_wdata = stg_q_r;
        end else if (p_src_ok_r) begin
          fl_wdata = flash_q_r;
        end else begin
          fl_wdata = ERASED;
        end
      end
      if ((cnt_r >= sweep_end) && !p_v_r) begin
        cnt_nxt = '0;
        case (state_r)
          ST_CHECK: begin
            state_nxt = need_r ? ST_ALIGN : ST_PROG;
          end
          ST_PROG: begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_WRITE;
            state_nxt     = ST_IDLE;
          end
          ST_COPY_TB: begin
            state_nxt = ST_ERASE_T;
          end
          ST_COPY_BT: begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_WRITE;
            out_erase_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      flash_mem[fl_waddr[FA_W-1:0]] <= fl_wdata;
    end
    flash_q_r <= flash_mem[fl_raddr[FA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stg_mem[byte_count_r] <= in_write_data;
    end
    stg_q_r <= stg_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      byte_count_r <= '0;
      p_v_r        <= 1'b0;
      need_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_rd_ok_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      byte_count_r <= byte_count_nxt;
      p_v_r        <= p_v_nxt;
      need_r       <= need_nxt;
      out_valid_r  <= out_valid_nxt;
      out_rd_ok_r  <= out_rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_dst_r      <= p_dst_nxt;
    p_src_ok_r   <= p_src_ok_nxt;
    p_merge_r    <= p_merge_nxt;
    off_r        <= off_nxt;
    tgt_r        <= tgt_nxt;
    start_r      <= start_nxt;
    len_r        <= len_nxt;
    out_status_r <= out_status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_erase_r  <= out_erase_nxt;
  end

  // read byte comes straight from the flash read register
  assign out_valid       = out_valid_r;
  assign out_read_data   = out_rd_ok_r ? flash_q_r : '0;
  assign out_status      = out_status_r;
  assign out_result_kind = out_kind_r;
  assign out_did_erase   = out_erase_r;

endmodule

/* dv/sfbw_checker.sv */
// Checker for sector_flash_byte_writer: watches the request and result channels,
// predicts every result from its own copy of the flash array and compares in order.
// Depends on sfbw_pkg for widths and codes.
`timescale 1ns / 1ps
module sfbw_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        in_req_type,
  input  logic [sfbw_pkg::ADDR_W-1:0] in_start_addr,
  input  logic [sfbw_pkg::LEN_W-1:0]  in_length,
  input  logic [sfbw_pkg::DATA_W-1:0] in_write_data,
  input  logic                        in_last,
  input  logic                        out_valid,
  input  logic [sfbw_pkg::DATA_W-1:0] out_read_data,
  input  logic                        out_status,
  input  logic                        out_result_kind,
  input  logic                        out_did_erase,
  output int                          fail_count,
  output int                          pending
);
  import sfbw_pkg::*;

  localparam int unsigned FLASH_SZ  = FLASH_BYTES_DEF;
  localparam int unsigned SECTOR_SZ = SECTOR_BYTES_DEF;
  localparam int unsigned MAX_REQ   = MAX_REQUEST_DEF;
  localparam int unsigned USER_SZ   = (FLASH_BYTES_DEF > RESERVED_BYTES_DEF) ?
                                      FLASH_BYTES_DEF - RESERVED_BYTES_DEF : 0;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              status;
    logic              kind;
    logic              did_erase;
  } result_t;

  logic [DATA_W-1:0] flash_img [FLASH_SZ];
  logic [DATA_W-1:0] stage [STG_DEPTH];
  int unsigned       item_idx;
  result_t           expected_results [$];
  int                reported;

  function automatic logic [DATA_W-1:0] flash_rd(input int unsigned a);
    return (a < FLASH_SZ) ? flash_img[a] : ERASED;
  endfunction

  // programming can only clear bits
  function automatic void flash_and(input int unsigned a, input logic [DATA_W-1:0] v);
    if (a < FLASH_SZ) flash_img[a] = flash_img[a] & v;
  endfunction

  function automatic void sector_wipe(input int unsigned base);
    int unsigned i;
    for (i = 0; i < SECTOR_SZ; i++)
      if (base + i < FLASH_SZ) flash_img[base + i] = ERASED;
  endfunction

  // staged bytes replace offsets off..off+n-1 on the way
  function automatic void sector_move(input int unsigned src, input int unsigned dst,
                                      input int unsigned off, input int unsigned n);
    int unsigned i;
    logic [DATA_W-1:0] b;
    if (src == dst) return;
    for (i = 0; i < SECTOR_SZ; i++) begin
      b = flash_rd(src + i);
      if (i >= off && i < off + n && (i - off) < STG_DEPTH) b = stage[i - off];
      flash_and(dst + i, b);
    end
  endfunction

  function automatic bit predict_item(input logic wr, input logic [ADDR_W-1:0] sa,
                                      input logic [LEN_W-1:0] ln, input logic [DATA_W-1:0] wd,
                                      input logic lst, output result_t res);
    int unsigned idx, s, l, addr, staged, n, i, target;
    bit range_bad, need;
    logic [DATA_W-1:0] c;
    idx = item_idx;
    s = sa;
    l = ln;
    range_bad = (s + l) > USER_SZ;
    if (lst) item_idx = 0;
    else if (item_idx < MAX_REQ) item_idx++;
    res = '0;

    if (wr == REQ_READ) begin
      addr = s + idx;
      if (range_bad || addr >= USER_SZ) begin
        res.status = STAT_RANGE;
      end else begin
        res.read_data = flash_rd(addr);
        res.status = STAT_OK;
      end
      res.kind = KIND_READ;
      return 1'b1;
    end

    if (idx < MAX_REQ && idx < STG_DEPTH) stage[idx] = wd;
    if (!lst) return 1'b0;

    res.kind = KIND_WRITE;
    if (range_bad) begin
      res.status = STAT_RANGE;
      return 1'b1;
    end
    res.status = STAT_OK;

    staged = (idx + 1 > MAX_REQ) ? MAX_REQ : idx + 1;
    n = (l < staged) ? l : staged;
    need = 1'b0;
    for (i = 0; i < n && !need; i++) begin
      c = flash_rd(s + i);
      if (c != stage[i] && c != ERASED) need = 1'b1;
    end

    if (!need) begin
      for (i = 0; i < n; i++) flash_and(s + i, stage[i]);
    end else begin
      // backup sector holds the first reserved byte; only the start sector is rebuilt
      target = (s / SECTOR_SZ) * SECTOR_SZ;
      sector_wipe((USER_SZ / SECTOR_SZ) * SECTOR_SZ);
      sector_move(target, (USER_SZ / SECTOR_SZ) * SECTOR_SZ, 0, 0);
      sector_wipe(target);
      sector_move((USER_SZ / SECTOR_SZ) * SECTOR_SZ, target, s - target, n);
      res.did_erase = 1'b1;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    result_t got, exp_r, pred;
    if (!rst_n) begin
      foreach (flash_img[i]) flash_img[i] = ERASED;
      foreach (stage[i]) stage[i] = '0;
      item_idx = 0;
      expected_results.delete();
      fail_count = 0;
      reported = 0;
      pending = 0;
    end else begin
      if (out_valid) begin
        got = '{out_read_data, out_status, out_result_kind, out_did_erase};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected result rd=%02h status=%0d kind=%0d erase=%0d",
                     $realtime, got.read_data, got.status, got.kind, got.did_erase);
          end
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch exp rd=%02h status=%0d kind=%0d erase=%0d,",
                       $realtime, exp_r.read_data, exp_r.status, exp_r.kind,
                       exp_r.did_erase, " got rd=%02h status=%0d kind=%0d erase=%0d",
                       got.read_data, got.status, got.kind, got.did_erase);
            end
          end
        end
      end
      if (start && !busy) begin
        if (predict_item(in_req_type, in_start_addr, in_length, in_write_data, in_last,
                         pred))
          expected_results.push_back(pred);
      end
      pending = expected_results.size();
    end
  end

endmodule

/* dv/tb_top.sv */
// Top of the sector_flash_byte_writer testbench: clock, reset, request stimulus,
// watchdog and verdict. Depends on sfbw_pkg, sfbw_checker and the block itself.
`timescale 1ns / 1ps
module tb_top;
  import sfbw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEM_TARGET    = 1600;
  localparam int DRAIN_CYCLES   = 64;
  localparam int USER_END       = FLASH_BYTES_DEF - RESERVED_BYTES_DEF;
  localparam int IDLE_PCTS [4]  = '{0, 53, 0, 22};

  typedef enum int {FILL_RANDOM, FILL_REPEAT, FILL_ONES, FILL_ZEROS} fill_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_req_type;
  logic [ADDR_W-1:0] in_start_addr;
  logic [LEN_W-1:0]  in_length;
  logic [DATA_W-1:0] in_write_data;
  logic              in_last;
  logic              out_valid;
  logic [DATA_W-1:0] out_read_data;
  logic              out_status;
  logic              out_result_kind;
  logic              out_did_erase;
  int                fail_count;
  int                pending;

  int                items_sent;
  int                idle_pct;
  int                quiet_cycles;
  logic [DATA_W-1:0] prev_data [STG_DEPTH];
  logic [ADDR_W-1:0] prev_start;
  logic [LEN_W-1:0]  prev_len;
  bit                have_prev;

  sector_flash_byte_writer u_dut (.*);
  sfbw_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // nothing accepted on either channel for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] pick_addr();
    int r;
    r = $urandom_range(99, 0);
    if (r < 40) return ADDR_W'($urandom_range(63, 0));
    if (r < 60) return ADDR_W'($urandom_range(7, 1) * 512 + $urandom_range(32, 0) - 16);
    if (r < 80) return ADDR_W'($urandom_range(USER_END + 40, USER_END - 300));
    return ADDR_W'($urandom_range(4095, 0));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic wr, input logic [ADDR_W-1:0] sa,
                              input logic [LEN_W-1:0] ln, input int n_items,
                              input bit with_last, input int mix_pct, input fill_t fill);
    int i;
    logic kind;
    logic [DATA_W-1:0] d;
    for (i = 0; i < n_items; i++) begin
      kind = ($urandom_range(99, 0) < mix_pct) ? ~wr : wr;
      case (fill)
        FILL_REPEAT: d = prev_data[i % STG_DEPTH];
        FILL_ONES:   d = ERASED;
        FILL_ZEROS:  d = '0;
        default:     d = DATA_W'($urandom);
      endcase
      while ($urandom_range(99, 0) < idle_pct) begin
        start         <= 1'b0;
        in_req_type   <= 1'($urandom);
        in_start_addr <= ADDR_W'($urandom);
        in_length     <= LEN_W'($urandom);
        in_write_data <= DATA_W'($urandom);
        in_last       <= 1'($urandom);
        @(negedge clk);
      end
      start         <= 1'b1;
      in_req_type   <= kind;
      in_start_addr <= sa;
      in_length     <= ln;
      in_write_data <= d;
      in_last       <= with_last && (i == n_items - 1);
      @(posedge clk);
      while (busy) @(posedge clk);
      @(negedge clk);
      items_sent++;
      if (kind == REQ_WRITE && i < STG_DEPTH) prev_data[i] = d;
    end
  endtask

  // hold off until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    int phase, quota_base, roll, lr;
    logic wr;
    logic [ADDR_W-1:0] sa;
    logic [LEN_W-1:0] ln;
    fill_t fill;

    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_READ;
    in_start_addr = '0;
    in_length = '0;
    in_write_data = '0;
    in_last = 1'b0;
    items_sent = 0;
    idle_pct = 0;
    have_prev = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full-length write first: fills staging entries 0 to 254 before anything reads them
    send_request(REQ_WRITE, 12'd0, 8'd255, 255, 1'b1, 0, FILL_RANDOM);
    send_request(REQ_WRITE, 12'd0, 8'd1, 1, 1'b1, 0, FILL_ZEROS);      // overwrite -> erase
    send_request(REQ_WRITE, 12'd3071, 8'd1, 1, 1'b1, 0, FILL_ZEROS);   // last user byte
    send_request(REQ_WRITE, 12'd3072, 8'd1, 1, 1'b1, 0, FILL_ONES);    // just out of range
    send_request(REQ_WRITE, 12'd3072, 8'd0, 1, 1'b1, 0, FILL_RANDOM);  // zero length
    send_request(REQ_WRITE, 12'd4095, 8'd255, 1, 1'b1, 0, FILL_RANDOM);
    send_request(REQ_READ, 12'd3070, 8'd2, 3, 1'b1, 0, FILL_RANDOM);   // runs past user end
    send_request(REQ_READ, 12'd4095, 8'd255, 1, 1'b1, 0, FILL_RANDOM);
    // straddle a sector edge twice: direct program, then erase path drops the tail
    send_request(REQ_WRITE, 12'd510, 8'd4, 4, 1'b1, 0, FILL_ZEROS);
    send_request(REQ_WRITE, 12'd510, 8'd4, 4, 1'b1, 0, FILL_ONES);
    send_request(REQ_WRITE, 12'd100, 8'd10, 2, 1'b1, 0, FILL_RANDOM);  // too few items
    send_request(REQ_WRITE, 12'd200, 8'd1, 3, 1'b1, 0, FILL_RANDOM);   // too many items
    send_request(REQ_WRITE, 12'd300, 8'd3, 3, 1'b1, 50, FILL_RANDOM);  // mixed kinds
    send_request(REQ_READ, 12'd40, 8'd2, 1, 1'b0, 0, FILL_RANDOM);     // no last marker
    send_request(REQ_WRITE, 12'd40, 8'd2, 1, 1'b1, 0, FILL_RANDOM);
    drain();

    // the random phases share what is left of the item budget
    quota_base = items_sent;
    for (phase = 0; phase < 4; phase++) begin
      idle_pct = IDLE_PCTS[phase];
      while (items_sent < quota_base + (phase + 1) * (ITEM_TARGET - quota_base) / 4) begin
        roll = $urandom_range(99, 0);
        if (roll < 1) begin
          // counter saturation, items past the limit are dropped
          send_request(REQ_WRITE, ADDR_W'($urandom_range(63, 0)), 8'd255,
                       $urandom_range(262, 256), 1'b1, 0, FILL_RANDOM);
        end else if (roll < 20) begin
          send_request(1'($urandom), pick_addr(), LEN_W'($urandom), $urandom_range(12, 1),
                       $urandom_range(99, 0) < 85, 30, FILL_RANDOM);
        end else if (roll < 30 && have_prev) begin
          // identical rewrite should skip the erase
          send_request(REQ_WRITE, prev_start, prev_len, (prev_len == 0) ? 1 : prev_len,
                       1'b1, 0, FILL_REPEAT);
        end else begin
          lr = $urandom_range(99, 0);
          if (lr < 3) ln = '0;
          else if (lr < 70) ln = LEN_W'($urandom_range(8, 1));
          else if (lr < 95) ln = LEN_W'($urandom_range(32, 9));
          else ln = LEN_W'($urandom_range(255, 33));
          sa = pick_addr();
          wr = 1'($urandom);
          lr = $urandom_range(99, 0);
          fill = (lr < 10) ? FILL_ONES : (lr < 15) ? FILL_ZEROS : FILL_RANDOM;
          send_request(wr, sa, ln, (ln == 0) ? 1 : ln, 1'b1, 0, fill);
          if (wr == REQ_WRITE) begin
            prev_start = sa;
            prev_len = ln;
            have_prev = 1'b1;
          end
        end
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
